// File: sv/rcsc_pkg.sv
// Package for the RC pulse soft cut-off sequencer: payload types, register indexes, states.
package rcsc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_RELAY_OPEN_DELAY  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RAMP_LENGTH       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RELAY_CLOSE_DELAY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_FLOOR       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_CEILING     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_THRESHOLD  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PULSE_WINDOW_LOW  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PULSE_WINDOW_HIGH = 3'd7;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] capture_time;
  } rcsc_in_t;

  typedef struct packed {
    logic [7:0]  duty_limit;
    logic        relay_closed;
    logic        enabled;
    logic [14:0] filtered_width;
  } rcsc_out_t;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_EDGE   = 13'b0000000000010,
    ST_WIN    = 13'b0000000000100,
    ST_FILT   = 13'b0000000001000,
    ST_REQ    = 13'b0000000010000,
    ST_APPLY  = 13'b0000000100000,
    ST_BOUND  = 13'b0000001000000,
    ST_DIST   = 13'b0000010000000,
    ST_DECIDE = 13'b0000100000000,
    ST_MUL    = 13'b0001000000000,
    ST_DIV    = 13'b0010000000000,
    ST_DONE   = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } rcsc_state_e;

endpackage

// File: sv/rc_pulse_soft_cutoff_sequencer.sv
// RC pulse soft cut-off sequencer: pulse filter, enable request and duty ramp sequencer.
// Sequence: a capture edge runs the edge, window, filter and request states as needed;
//   a tick runs apply, bound, distance and decide, and, when the duty limit lies on the
//   ramp, a 16x8 multiply and 8 restoring division steps, one quotient bit per cycle.
// Items: one at a time; the next item is accepted the cycle after the result is loaded
//   into the output register.
// Reset: asynchronous, active low; control and config registers return to defaults.
module rc_pulse_soft_cutoff_sequencer #(
  parameter int unsigned TIME_STEP = 3
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [rcsc_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [rcsc_pkg::CfgDataW-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  rcsc_pkg::rcsc_in_t                      in_data_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output rcsc_pkg::rcsc_out_t                     out_data_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] rod_q, rod_d;     // relay open delay
  logic [15:0] rlen_q, rlen_d;   // ramp length
  logic [15:0] rcd_q, rcd_d;     // relay close delay
  logic [7:0]  floor_q, floor_d;
  logic [7:0]  ceil_q, ceil_d;
  logic [14:0] thr_q, thr_d;
  logic [14:0] win_lo_q, win_lo_d;
  logic [14:0] win_hi_q, win_hi_d;

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  rcsc_pkg::rcsc_state_e state_q, state_d;
  logic        expect_rise_q, expect_rise_d;
  logic [15:0] pulse_start_q, pulse_start_d;
  logic [15:0] filt_q, filt_d;
  logic        req_q, req_d;
  logic        applied_q, applied_d;
  logic [31:0] rus_q, rus_d;     // ramp up start
  logic [31:0] rde_q, rde_d;     // ramp down end
  logic [31:0] now_q, now_d;
  logic [7:0]  limit_q, limit_d;
  logic        relay_q, relay_d;
  logic        out_valid_q, out_valid_d;

  // Work registers of the sequencer (no reset needed)
  logic [15:0] cap_q, cap_d;
  logic [14:0] width_q, width_d;
  logic [19:0] acc_q, acc_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] dist_q, dist_d;
  logic        lt_q, lt_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  rcsc_pkg::rcsc_out_t out_data_q, out_data_d;

  // ---------------------------------------------------------------------------
  // Shared arithmetic helpers
  // ---------------------------------------------------------------------------
  logic [15:0] len;        // ramp length, zero taken as one
  logic [7:0]  span;       // ceiling - floor, zero if ceiling is below floor
  logic [31:0] base;       // ramp up start or ramp down end, by applied request
  logic [32:0] diff;       // one difference signal serves both ramp directions
  logic [15:0] dist_cap;
  logic [23:0] prod;
  logic [16:0] div_trial;
  logic        div_ge;
  logic        accept_in;
  logic        load_out;

  assign len  = (rlen_q == 16'd0) ? 16'd1 : rlen_q;
  assign span = (ceil_q >= floor_q) ? (ceil_q - floor_q) : 8'd0;
  assign base = applied_q ? rus_q : rde_q;
  assign diff = applied_q ? ({1'b0, now_q} - {1'b0, rus_q})
                          : ({1'b0, rde_q} - {1'b0, now_q});
  assign dist_cap  = (dist_q > {16'd0, len}) ? len : dist_q[15:0];
  assign prod      = {8'd0, dist_cap} * {16'd0, span};
  assign div_trial = {rem_q, quo_q[7]};
  assign div_ge    = (div_trial >= {1'b0, len});

  assign accept_in  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rcsc_pkg::ST_IDLE);
  assign load_out   = (state_q == rcsc_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    rod_d      = rod_q;
    rlen_d     = rlen_q;
    rcd_d      = rcd_q;
    floor_d    = floor_q;
    ceil_d     = ceil_q;
    thr_d      = thr_q;
    win_lo_d   = win_lo_q;
    win_hi_d   = win_hi_q;

    state_d       = state_q;
    expect_rise_d = expect_rise_q;
    pulse_start_d = pulse_start_q;
    filt_d        = filt_q;
    req_d         = req_q;
    applied_d     = applied_q;
    rus_d         = rus_q;
    rde_d         = rde_q;
    now_d         = now_q;
    limit_d       = limit_q;
    relay_d       = relay_q;
    out_valid_d   = out_valid_q;

    cap_d      = cap_q;
    width_d    = width_q;
    acc_d      = acc_q;
    sum_d      = sum_q;
    dist_d     = dist_q;
    lt_d       = lt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    out_data_d = out_data_q;

    // Register writes only while the sequencer is idle: the user's duty, unchecked.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rcsc_pkg::REG_RELAY_OPEN_DELAY:  rod_d    = cfg_wdata_i;
        rcsc_pkg::REG_RAMP_LENGTH:       rlen_d   = cfg_wdata_i;
        rcsc_pkg::REG_RELAY_CLOSE_DELAY: rcd_d    = cfg_wdata_i;
        rcsc_pkg::REG_LIMIT_FLOOR:       floor_d  = cfg_wdata_i[7:0];
        rcsc_pkg::REG_LIMIT_CEILING:     ceil_d   = cfg_wdata_i[7:0];
        rcsc_pkg::REG_SWITCH_THRESHOLD:  thr_d    = cfg_wdata_i[14:0];
        rcsc_pkg::REG_PULSE_WINDOW_LOW:  win_lo_d = cfg_wdata_i[14:0];
        rcsc_pkg::REG_PULSE_WINDOW_HIGH: win_hi_d = cfg_wdata_i[14:0];
        default: ;
      endcase
    end

    // Drop the result once the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rcsc_pkg::ST_IDLE: begin
        if (accept_in) begin
          cap_d   = in_data_i.capture_time;
          state_d = (in_data_i.func == rcsc_pkg::FUNC_EDGE) ? rcsc_pkg::ST_EDGE
                                                             : rcsc_pkg::ST_APPLY;
        end
      end

      // ---- capture edge path ----
      rcsc_pkg::ST_EDGE: begin
        if (expect_rise_q) begin
          expect_rise_d = 1'b0;
          pulse_start_d = cap_q;
          state_d       = rcsc_pkg::ST_OUT;
        end else begin
          // width is half the wrapped 16-bit difference
          expect_rise_d = 1'b1;
          width_d       = 15'((cap_q - pulse_start_q) >> 1);
          state_d       = rcsc_pkg::ST_WIN;
        end
      end
      rcsc_pkg::ST_WIN: begin
        if (width_q >= win_lo_q && width_q <= win_hi_q) begin
          acc_d   = ({4'd0, filt_q} << 3) - {4'd0, filt_q} + {5'd0, width_q};
          state_d = rcsc_pkg::ST_FILT;
        end else begin
          state_d = rcsc_pkg::ST_OUT;
        end
      end
      rcsc_pkg::ST_FILT: begin
        filt_d  = acc_q[18:3];
        state_d = rcsc_pkg::ST_REQ;
      end
      rcsc_pkg::ST_REQ: begin
        req_d   = !(filt_q > {1'b0, thr_q});
        state_d = rcsc_pkg::ST_OUT;
      end

      // ---- tick path ----
      rcsc_pkg::ST_APPLY: begin
        if (req_q != applied_q) begin
          applied_d = req_q;
          if (req_q) begin
            rus_d = now_q + {16'd0, rod_q};
          end else begin
            rde_d = now_q + {16'd0, rlen_q};
          end
        end
        state_d = rcsc_pkg::ST_BOUND;
      end
      rcsc_pkg::ST_BOUND: begin
        // end of ramp up, or moment the relay may close
        sum_d   = base + (applied_q ? {16'd0, rlen_q} : {16'd0, rcd_q});
        state_d = rcsc_pkg::ST_DIST;
      end
      rcsc_pkg::ST_DIST: begin
        dist_d = diff[31:0];
        lt_d   = applied_q ? diff[32] : (!diff[32] && (diff[31:0] != 32'd0));
        state_d = rcsc_pkg::ST_DECIDE;
      end
      rcsc_pkg::ST_DECIDE: begin
        now_d = now_q + 32'(TIME_STEP);
        if (applied_q) begin
          relay_d = 1'b0;
          if (lt_q) begin
            limit_d = 8'd0;
            state_d = rcsc_pkg::ST_OUT;
          end else if (now_q > sum_q) begin
            limit_d = ceil_q;
            state_d = rcsc_pkg::ST_OUT;
          end else begin
            state_d = rcsc_pkg::ST_MUL;
          end
        end else begin
          if (now_q > sum_q) begin
            relay_d = 1'b1;
          end
          if (lt_q) begin
            state_d = rcsc_pkg::ST_MUL;
          end else begin
            limit_d = 8'd0;
            state_d = rcsc_pkg::ST_OUT;
          end
        end
      end
      rcsc_pkg::ST_MUL: begin
        // quotient fits 8 bits since the product stays below len * 256
        rem_d   = prod[23:8];
        quo_d   = prod[7:0];
        cnt_d   = 3'd7;
        state_d = rcsc_pkg::ST_DIV;
      end
      rcsc_pkg::ST_DIV: begin
        rem_d = div_ge ? 16'(div_trial - {1'b0, len}) : div_trial[15:0];
        quo_d = {quo_q[6:0], div_ge};
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = rcsc_pkg::ST_DONE;
        end
      end
      rcsc_pkg::ST_DONE: begin
        limit_d = floor_q + quo_q;
        state_d = rcsc_pkg::ST_OUT;
      end

      // ---- result ----
      rcsc_pkg::ST_OUT: begin
        if (load_out) begin
          out_valid_d               = 1'b1;
          out_data_d.duty_limit     = limit_q;
          out_data_d.relay_closed   = relay_q;
          out_data_d.enabled        = applied_q;
          out_data_d.filtered_width = filt_q[14:0];
          state_d                   = rcsc_pkg::ST_IDLE;
        end
      end

      default: state_d = rcsc_pkg::ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_q         <= 16'd100;
      rlen_q        <= 16'd2048;
      rcd_q         <= 16'd1500;
      floor_q       <= 8'd16;
      ceil_q        <= 8'd32;
      thr_q         <= 15'd1500;
      win_lo_q      <= 15'd800;
      win_hi_q      <= 15'd2200;
      state_q       <= rcsc_pkg::ST_IDLE;
      expect_rise_q <= 1'b1;
      pulse_start_q <= 16'd0;
      filt_q        <= 16'd1000;
      req_q         <= 1'b1;
      applied_q     <= 1'b1;
      rus_q         <= 32'd0;
      rde_q         <= 32'd0;
      now_q         <= 32'd0;
      limit_q       <= 8'd32;
      relay_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      rod_q         <= rod_d;
      rlen_q        <= rlen_d;
      rcd_q         <= rcd_d;
      floor_q       <= floor_d;
      ceil_q        <= ceil_d;
      thr_q         <= thr_d;
      win_lo_q      <= win_lo_d;
      win_hi_q      <= win_hi_d;
      state_q       <= state_d;
      expect_rise_q <= expect_rise_d;
      pulse_start_q <= pulse_start_d;
      filt_q        <= filt_d;
      req_q         <= req_d;
      applied_q     <= applied_d;
      rus_q         <= rus_d;
      rde_q         <= rde_d;
      now_q         <= now_d;
      limit_q       <= limit_d;
      relay_q       <= relay_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Work and payload registers
  always_ff @(posedge clk_i) begin
    cap_q      <= cap_d;
    width_q    <= width_d;
    acc_q      <= acc_d;
    sum_q      <= sum_d;
    dist_q     <= dist_d;
    lt_q       <= lt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted item keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> in_stall_o)
    else $error("input not stalled after accept");

  // The relay is never reported closed while the output is enabled.
  a_relay_vs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.relay_closed && out_data_o.enabled))
    else $error("relay closed while enabled");

  // A new result only appears from the result state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == rcsc_pkg::ST_OUT))
    else $error("result raised outside result state");

endmodule

// File: test/testbench.sv
// Testbench for the RC pulse soft cut-off sequencer: directed and random items checked against a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import rcsc_pkg::*;

  localparam int unsigned TimeStep    = 3;
  // Longest quiet stretch: a tick on the ramp plus the random gaps on each side sits far below this.
  localparam int unsigned StallLimit  = 2000;
  // Settle time after the last result: one full ramp tick plus margin.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 115;
  localparam int unsigned PhaseCount  = 9;

  // Tracks the sequencer state, predicts the status each item yields and checks the block.
  class cutoff_tracker;
    // register copies
    bit [15:0] open_delay, ramp_len, close_delay;
    bit [7:0]  floor_lim, ceil_lim;
    bit [14:0] threshold, win_low, win_high;
    // pulse filter and sequencer state
    bit        awaiting_rise;
    bit [15:0] rise_time;
    bit [15:0] filtered;
    bit        req_on, applied_on;
    bit [31:0] up_start, down_end, now_units;
    bit [7:0]  limit;
    bit        relay;
    rcsc_out_t due_status[$];
    int        failures;

    function new();
      open_delay    = 16'd100;
      ramp_len      = 16'd2048;
      close_delay   = 16'd1500;
      floor_lim     = 8'd16;
      ceil_lim      = 8'd32;
      threshold     = 15'd1500;
      win_low       = 15'd800;
      win_high      = 15'd2200;
      awaiting_rise = 1'b1;
      rise_time     = '0;
      filtered      = 16'd1000;
      req_on        = 1'b1;
      applied_on    = 1'b1;
      up_start      = '0;
      down_end      = '0;
      now_units     = '0;
      limit         = 8'd32;
      relay         = 1'b0;
      failures      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_RELAY_OPEN_DELAY:  open_delay  = value;
        REG_RAMP_LENGTH:       ramp_len    = value;
        REG_RELAY_CLOSE_DELAY: close_delay = value;
        REG_LIMIT_FLOOR:       floor_lim   = value[7:0];
        REG_LIMIT_CEILING:     ceil_lim    = value[7:0];
        REG_SWITCH_THRESHOLD:  threshold   = value[14:0];
        REG_PULSE_WINDOW_LOW:  win_low     = value[14:0];
        REG_PULSE_WINDOW_HIGH: win_high    = value[14:0];
        default: ;
      endcase
    endfunction

    // Duty limit at a given distance into the ramp; zero length acts as one, an inverted
    // floor/ceiling pair gives a flat ramp, and the distance is capped at the length.
    function bit [7:0] ramp_limit(bit [31:0] offset);
      bit [31:0] len;
      bit [31:0] span;
      bit [63:0] scaled;
      len = (ramp_len != 16'd0) ? 32'(ramp_len) : 32'd1;
      span = (ceil_lim >= floor_lim) ? 32'(ceil_lim - floor_lim) : 32'd0;
      if (offset > len) offset = len;
      scaled = (64'(offset) * 64'(span)) / 64'(len);
      return 8'(64'(floor_lim) + scaled);
    endfunction

    function void advance_tick();
      bit [31:0] up_end;
      bit [31:0] close_at;
      if (req_on != applied_on) begin
        applied_on = req_on;
        if (applied_on) up_start = now_units + 32'(open_delay);
        else down_end = now_units + 32'(ramp_len);
      end
      up_end   = up_start + 32'(ramp_len);
      close_at = down_end + 32'(close_delay);
      if (applied_on) begin
        relay = 1'b0;
        if (now_units < up_start) limit = 8'd0;
        else if (now_units > up_end) limit = ceil_lim;
        else limit = ramp_limit(now_units - up_start);
      end else begin
        limit = (now_units < down_end) ? ramp_limit(down_end - now_units) : 8'd0;
        if (now_units > close_at) relay = 1'b1;
      end
      now_units = now_units + 32'(TimeStep);
    endfunction

    function void take_edge(bit [15:0] stamp);
      bit [15:0] diff;
      bit [15:0] width;
      if (awaiting_rise) begin
        awaiting_rise = 1'b0;
        rise_time = stamp;
      end else begin
        awaiting_rise = 1'b1;
        diff  = stamp - rise_time;
        width = diff >> 1;
        if (width >= 16'(win_low) && width <= 16'(win_high)) begin
          filtered = 16'((7 * 32'(filtered) + 32'(width)) / 8);
          req_on = (filtered > 16'(threshold)) ? 1'b0 : 1'b1;
        end
      end
    endfunction

    function void accept_item(rcsc_in_t item);
      rcsc_out_t due;
      if (item.func == FUNC_EDGE) take_edge(item.capture_time);
      else advance_tick();
      due.duty_limit     = limit;
      due.relay_closed   = relay;
      due.enabled        = applied_on;
      due.filtered_width = filtered[14:0];
      due_status.push_back(due);
    endfunction

    function void check_status(rcsc_out_t got);
      rcsc_out_t want;
      if (due_status.size() == 0) begin
        $error("status with no item pending: duty_limit %0d filtered_width %0d",
               got.duty_limit, got.filtered_width);
        failures++;
      end else begin
        want = due_status.pop_front();
        if (got.duty_limit !== want.duty_limit) begin
          $error("duty_limit: expected %0d, got %0d", want.duty_limit, got.duty_limit);
          failures++;
        end
        if (got.relay_closed !== want.relay_closed) begin
          $error("relay_closed: expected %0d, got %0d", want.relay_closed, got.relay_closed);
          failures++;
        end
        if (got.enabled !== want.enabled) begin
          $error("enabled: expected %0d, got %0d", want.enabled, got.enabled);
          failures++;
        end
        if (got.filtered_width !== want.filtered_width) begin
          $error("filtered_width: expected %0d, got %0d",
                 want.filtered_width, got.filtered_width);
          failures++;
        end
      end
    endfunction

    function int pending();
      return due_status.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  rcsc_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  rcsc_out_t           out_data;

  cutoff_tracker tracker;

  // Sender side bookkeeping: edge polarity as the block sees it, the last rising stamp,
  // and the direction the pulse widths are currently pushing the filter.
  bit                  next_rising = 1'b1;
  logic [15:0]         rise_stamp  = '0;
  bit                  toward_high = 1'b1;
  int                  pulses_left = 12;
  // Drop all idling on both sides while set.
  bit                  steady      = 1'b0;
  logic [15:0]         cfg_words [8];
  int unsigned         quiet_cycles = 0;

  rc_pulse_soft_cutoff_sequencer #(
    .TIME_STEP(TimeStep)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note every accepted item and check every accepted status at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_status(out_data);
      if (in_valid && !in_stall) tracker.accept_item(in_data);
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: hold stall for a random number of cycles per status, whether or not one is
  // waiting, then take the next status as soon as it shows up.
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input rcsc_in_t item);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tick();
    rcsc_in_t item;
    item.func         = FUNC_TICK;
    item.capture_time = 16'($urandom());
    send_item(item);
  endtask

  task automatic send_edge(input logic [15:0] stamp);
    rcsc_in_t item;
    item.func         = FUNC_EDGE;
    item.capture_time = stamp;
    if (next_rising) rise_stamp = stamp;
    next_rising = !next_rising;
    send_item(item);
  endtask

  task automatic send_pair(input logic [15:0] rise, input logic [15:0] fall);
    send_edge(rise);
    send_edge(fall);
  endtask

  // Drop valid, then hold off until every pending status has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    cfg_words[idx] = value;
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pick a pulse width: mostly near the window edge the filter is being pushed toward,
  // sometimes right on or just past a window bound, sometimes anything at all.
  function automatic logic [15:0] pick_width();
    int unsigned lo, hi, swap, band, roll;
    logic [15:0] width;
    lo = cfg_words[REG_PULSE_WINDOW_LOW] & 16'h7FFF;
    hi = cfg_words[REG_PULSE_WINDOW_HIGH] & 16'h7FFF;
    if (lo > hi) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    band = (hi - lo) / 8;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      width = toward_high ? 16'(hi - $urandom_range(0, band)) : 16'(lo + $urandom_range(0, band));
    end else if (roll < 90) begin
      case ($urandom_range(0, 3))
        0: width = (lo > 0) ? 16'(lo - 1) : 16'(lo);
        1: width = 16'(lo);
        2: width = 16'(hi);
        default: width = (hi < 32767) ? 16'(hi + 1) : 16'(hi);
      endcase
    end else begin
      width = 16'($urandom_range(0, 32767));
    end
    return width;
  endfunction

  // Write every register for one phase: two phases take the extremes, the rest get short
  // ramps and delays so that enable and disable sequences finish within the phase.
  task automatic setup_phase(input int phase);
    logic [15:0] lo, floor_v;
    case (phase)
      3: begin
        write_reg(REG_RELAY_OPEN_DELAY, 16'd0);
        write_reg(REG_RAMP_LENGTH, 16'd0);
        write_reg(REG_RELAY_CLOSE_DELAY, 16'd0);
        write_reg(REG_LIMIT_FLOOR, 16'd0);
        write_reg(REG_LIMIT_CEILING, 16'd0);
        write_reg(REG_SWITCH_THRESHOLD, 16'd0);
        write_reg(REG_PULSE_WINDOW_LOW, 16'd0);
        write_reg(REG_PULSE_WINDOW_HIGH, 16'd0);
      end
      5: begin
        write_reg(REG_RELAY_OPEN_DELAY, 16'hFFFF);
        write_reg(REG_RAMP_LENGTH, 16'hFFFF);
        write_reg(REG_RELAY_CLOSE_DELAY, 16'hFFFF);
        write_reg(REG_LIMIT_FLOOR, 16'hFFFF);
        write_reg(REG_LIMIT_CEILING, 16'hFFFF);
        write_reg(REG_SWITCH_THRESHOLD, 16'hFFFF);
        write_reg(REG_PULSE_WINDOW_LOW, 16'hFFFF);
        write_reg(REG_PULSE_WINDOW_HIGH, 16'hFFFF);
      end
      default: begin
        lo      = 16'($urandom_range(100, 1500));
        floor_v = 16'($urandom_range(0, 255));
        write_reg(REG_RELAY_OPEN_DELAY, 16'($urandom_range(0, 40)));
        write_reg(REG_RAMP_LENGTH, ($urandom_range(0, 9) == 0) ?
                  16'($urandom_range(0, 2)) : 16'($urandom_range(3, 90)));
        write_reg(REG_RELAY_CLOSE_DELAY, 16'($urandom_range(0, 90)));
        write_reg(REG_LIMIT_FLOOR, floor_v);
        write_reg(REG_LIMIT_CEILING, ($urandom_range(0, 4) == 0) ?
                  16'($urandom_range(0, 255)) : 16'($urandom_range(floor_v, 255)));
        write_reg(REG_PULSE_WINDOW_LOW, lo);
        write_reg(REG_PULSE_WINDOW_HIGH, 16'(lo + $urandom_range(200, 3000)));
        write_reg(REG_SWITCH_THRESHOLD,
                  16'($urandom_range(lo, cfg_words[REG_PULSE_WINDOW_HIGH])));
      end
    endcase
  endtask

  // Mostly ticks and well-formed rise/fall pairs whose widths swing the filter across the
  // threshold in bursts; a few stray edges knock the pairing out of step.
  task automatic random_phase(input int count);
    int k;
    int roll;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_tick();
      end else if (roll < 92) begin
        if (next_rising) begin
          send_edge(16'($urandom()));
        end else begin
          send_edge(rise_stamp + 16'(pick_width() * 2) + 16'($urandom_range(0, 1)));
          if (pulses_left == 0) begin
            toward_high = !toward_high;
            pulses_left = $urandom_range(8, 24);
          end else begin
            pulses_left--;
          end
        end
      end else begin
        send_edge(16'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    tracker   = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_words[REG_RELAY_OPEN_DELAY]  = 16'd100;
    cfg_words[REG_RAMP_LENGTH]       = 16'd2048;
    cfg_words[REG_RELAY_CLOSE_DELAY] = 16'd1500;
    cfg_words[REG_LIMIT_FLOOR]       = 16'd16;
    cfg_words[REG_LIMIT_CEILING]     = 16'd32;
    cfg_words[REG_SWITCH_THRESHOLD]  = 16'd1500;
    cfg_words[REG_PULSE_WINDOW_LOW]  = 16'd800;
    cfg_words[REG_PULSE_WINDOW_HIGH] = 16'd2200;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: first tick sits at the very start of the ramp.
    send_tick();
    // Zero width after a timer wrap, then the widest possible pulse: both rejected.
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h0000, 16'hFFFF);
    // Window bounds: lowest accepted, highest accepted across a wrap with an odd count,
    // and one unit outside on each side.
    send_pair(16'h1000, 16'h1000 + 16'd1600);
    send_pair(16'hF000, 16'hF000 + 16'd4401);
    send_pair(16'h2000, 16'h2000 + 16'd1598);
    send_pair(16'h3000, 16'h3000 + 16'd4402);

    // Zero ramp length with the ceiling below the floor: disable and let the relay close.
    drain();
    write_reg(REG_SWITCH_THRESHOLD, 16'd0);
    write_reg(REG_RAMP_LENGTH, 16'd0);
    write_reg(REG_LIMIT_FLOOR, 16'd200);
    write_reg(REG_LIMIT_CEILING, 16'd10);
    write_reg(REG_RELAY_CLOSE_DELAY, 16'd0);
    write_reg(REG_RELAY_OPEN_DELAY, 16'd0);
    send_pair(16'h0000, 16'd2000);
    send_tick();
    send_tick();

    // Re-enable onto a long ramp, then start the ramp down.
    drain();
    write_reg(REG_SWITCH_THRESHOLD, 16'h7FFF);
    write_reg(REG_LIMIT_FLOOR, 16'd5);
    write_reg(REG_LIMIT_CEILING, 16'd250);
    write_reg(REG_RAMP_LENGTH, 16'd300);
    send_pair(16'h0100, 16'h0100 + 16'd2000);
    send_tick();
    drain();
    write_reg(REG_SWITCH_THRESHOLD, 16'd0);
    send_pair(16'h0200, 16'h0200 + 16'd2000);
    send_tick();

    // Shrink the ramp mid-way down: the remaining distance overshoots and gets capped.
    drain();
    write_reg(REG_RAMP_LENGTH, 16'd2);
    send_tick();

    // Empty window: nothing is accepted.
    drain();
    write_reg(REG_PULSE_WINDOW_LOW, 16'd2000);
    write_reg(REG_PULSE_WINDOW_HIGH, 16'd1000);
    send_pair(16'h0300, 16'h0300 + 16'd3000);

    // Random phases; each one starts with the sender holding off until all is returned.
    for (phase = 0; phase < PhaseCount; phase++) begin
      drain();
      setup_phase(phase);
      steady = (phase == 2 || phase == 6);
      random_phase(PhaseItems);
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
